// ----- src/bre_pkg.sv -----
// Shared types and constants for the bilevel run-length row encoder.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package bre_pkg;

    localparam int VALUE_W   = 13;
    localparam int KIND_W    = 2;
    localparam int WIDTH_W   = 13;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    // pixel combine operations
    localparam logic [OP_W-1:0] OP_PASS_A = 2'd0;
    localparam logic [OP_W-1:0] OP_AND    = 2'd1;
    localparam logic [OP_W-1:0] OP_OR     = 2'd2;
    localparam logic [OP_W-1:0] OP_XOR    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_OP = 1'd1;

    // All results one pixel causes: an optional leading result (start colour
    // or finished run), then optionally the closing run plus end marker.
    typedef struct packed {
        logic                first_vld;
        logic [KIND_W-1:0]   first_kind;
        logic [VALUE_W-1:0]  lead_value;
        logic                end_vld;
        logic [VALUE_W-1:0]  end_run;
    } bundle_t;

endpackage

`default_nettype wire

// ----- src/bre_encoder.sv -----
// Row state, configuration registers and per-pixel result bundle.
// Depends on bre_pkg.
`default_nettype none

module bre_encoder #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [bre_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bre_pkg::WIDTH_W-1:0]     cfg_data,
    input  wire logic                            pix_accept,
    input  wire logic                            pixel_a,
    input  wire logic                            pixel_b,
    output logic                                 push,
    output bre_pkg::bundle_t                     bundle
);

    localparam int WMAX  = (1 << bre_pkg::WIDTH_W) - 1;
    localparam int W_CAP = (MAX_WIDTH > WMAX) ? WMAX : MAX_WIDTH;
    localparam int COL_W = (W_CAP > 1) ? $clog2(W_CAP) : 1;
    localparam logic [bre_pkg::WIDTH_W-1:0] WIDTH_CAP = bre_pkg::WIDTH_W'(W_CAP);

    logic [bre_pkg::WIDTH_W-1:0] row_width_reg;
    logic [bre_pkg::OP_W-1:0]    combine_op_reg;
    logic [COL_W-1:0]            column_reg,   column_next;
    logic                        prev_reg;
    logic [bre_pkg::VALUE_W-1:0] run_reg,      run_next;

    logic [bre_pkg::WIDTH_W-1:0] width_eff;
    logic                        pix;
    logic                        row_first;
    logic                        row_last;
    logic                        changed;
    logic [bre_pkg::VALUE_W-1:0] run_cur;

    always_comb
    begin
        width_eff = row_width_reg;
        if (width_eff == '0)
            width_eff = bre_pkg::WIDTH_W'(1);
        if (width_eff > WIDTH_CAP)
            width_eff = WIDTH_CAP;
    end

    always_comb
    begin
        unique case (combine_op_reg)
            bre_pkg::OP_AND: pix = pixel_a & pixel_b;
            bre_pkg::OP_OR:  pix = pixel_a | pixel_b;
            bre_pkg::OP_XOR: pix = pixel_a ^ pixel_b;
            default:         pix = pixel_a;
        endcase
    end

    assign row_first = (column_reg == '0);
    assign changed   = (pix != prev_reg);
    assign row_last  = ({1'b0, (bre_pkg::WIDTH_W)'(column_reg)} + 14'd1) >= {1'b0, width_eff};
    assign run_cur   = ((row_first || changed) ? '0 : run_reg) + bre_pkg::VALUE_W'(1);

    always_comb
    begin
        bundle.first_vld   = row_first || changed;
        bundle.first_kind  = row_first ? bre_pkg::KIND_START : bre_pkg::KIND_RUN;
        bundle.lead_value  = row_first ? bre_pkg::VALUE_W'(pix) : run_reg;
        bundle.end_vld     = row_last;
        bundle.end_run     = run_cur;
        push               = pix_accept && (bundle.first_vld || bundle.end_vld);
        if (row_last)
        begin
            column_next = '0;
            run_next    = '0;
        end
        else
        begin
            column_next = column_reg + COL_W'(1);
            run_next    = run_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg  <= bre_pkg::WIDTH_W'(1);
            combine_op_reg <= bre_pkg::OP_PASS_A;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bre_pkg::REG_ROW_WIDTH:  row_width_reg  <= cfg_data;
                bre_pkg::REG_COMBINE_OP: combine_op_reg <= cfg_data[bre_pkg::OP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            prev_reg   <= 1'b0;
            run_reg    <= '0;
        end
        else if (pix_accept)
        begin
            column_reg <= column_next;
            prev_reg   <= pix;
            run_reg    <= run_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bre_queue.sv -----
// Small queue of result bundles between the encoder and the serializer.
// Depends on bre_pkg.
`default_nettype none

module bre_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  bre_pkg::bundle_t push_data,
    input  wire logic        pop,
    output logic             full,
    output logic             nonempty,
    output bre_pkg::bundle_t head
);

    localparam int CNT_W = bre_pkg::QPTR_W + 1;

    bre_pkg::bundle_t            mem [bre_pkg::QUEUE_DEPTH];
    logic [bre_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [bre_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]            count_reg;

    assign full     = (count_reg == CNT_W'(bre_pkg::QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + bre_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + bre_pkg::QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- src/bre_serializer.sv -----
// Splits the head bundle into single results and holds the output register.
// Depends on bre_pkg.
`default_nettype none

module bre_serializer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        nonempty,
    input  bre_pkg::bundle_t                 head,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bre_pkg::KIND_W-1:0]       out_kind,
    output logic [bre_pkg::VALUE_W-1:0]      out_value,
    output logic                             out_last
);

    logic [1:0]                  step_reg;
    logic                        valid_reg;
    logic [bre_pkg::KIND_W-1:0]  kind_reg;
    logic [bre_pkg::VALUE_W-1:0] value_reg;
    logic                        last_reg;

    logic                        load;
    logic [1:0]                  n_items;
    logic [1:0]                  pos;
    logic [bre_pkg::KIND_W-1:0]  kind_next;
    logic [bre_pkg::VALUE_W-1:0] value_next;
    logic                        last_next;

    assign load = nonempty && (!valid_reg || out_ready);

    always_comb
    begin
        n_items = {head.end_vld, 1'b0} + {1'b0, head.first_vld};
        pos     = step_reg - {1'b0, head.first_vld};
        if (head.first_vld && step_reg == 2'd0)
        begin
            kind_next  = head.first_kind;
            value_next = head.lead_value;
        end
        else if (pos == 2'd0)
        begin
            kind_next  = bre_pkg::KIND_RUN;
            value_next = head.end_run;
        end
        else
        begin
            kind_next  = bre_pkg::KIND_END;
            value_next = '0;
        end
        last_next = (step_reg == n_items - 2'd1);
        pop       = load && last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            step_reg  <= last_next ? 2'd0 : step_reg + 2'd1;
            valid_reg <= 1'b1;
        end
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ----- src/bilevel_rle_row_encoder.sv -----
// Top level of the bilevel run-length row encoder.
// Depends on bre_pkg, bre_encoder, bre_queue and bre_serializer.
//
//  channel   signals                              request carries
//  --------  -----------------------------------  ---------------------------------
//  s_axis    s_tvalid s_tready s_tdata            one pixel pair
//  m_axis    m_tvalid m_tready m_tdata m_tuser     one result: kind, value, last
//            m_tlast
//  cfg       cfg_valid cfg_ready cfg_index         one register write
//            cfg_data
//
// A pixel request is taken at the edge it is offered and lands in the bundle
// queue; its first result is loaded into the output register once that register
// is empty or being taken, and is offered on m_axis from there. Further results of
// the same pixel follow one per cycle while m_tready stays high.
// Rate is set by the output port: one result per cycle while m_tready is high.
// Each pixel with results parks one bundle (up to three results) in a four-entry
// queue; s_tready drops only when that queue is full.
// Reset clears row position, run count, queue and output register; row_width
// returns to 1 and combine_op to pass-A. cfg_ready is always high.
`default_nettype none

module bilevel_rle_row_encoder #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // slave stream: [0] pixel_a, [1] pixel_b, [7:2] zero
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,
    // master stream: tdata [12:0] value, [15:13] zero; tuser [1:0] kind
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [15:0]                             m_tdata,
    output logic [bre_pkg::KIND_W-1:0]              m_tuser,
    output logic                                    m_tlast,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bre_pkg::WIDTH_W-1:0]        cfg_data
);

    logic                        pix_accept;
    logic                        push;
    logic                        pop;
    logic                        q_full;
    logic                        q_nonempty;
    bre_pkg::bundle_t            push_bundle;
    bre_pkg::bundle_t            head_bundle;
    logic [bre_pkg::VALUE_W-1:0] out_value;

    assign cfg_ready  = 1'b1;
    assign s_tready   = !q_full;
    assign pix_accept = s_tvalid && s_tready;

    bre_encoder #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_enc (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_accept (pix_accept),
        .pixel_a    (s_tdata[0]),
        .pixel_b    (s_tdata[1]),
        .push       (push),
        .bundle     (push_bundle)
    );

    // a pixel that causes no result pushes nothing
    bre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_bundle),
        .pop       (pop),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .head      (head_bundle)
    );

    bre_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .nonempty  (q_nonempty),
        .head      (head_bundle),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {3'b000, out_value};

endmodule

`default_nettype wire

// ----- src/bre_checker.sv -----
// Port-level checks for bilevel_rle_row_encoder, attached by bind.
// Depends on bre_pkg.
`default_nettype none

module bre_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [15:0]                   m_tdata,
    input wire logic [bre_pkg::KIND_W-1:0]    m_tuser,
    input wire logic                          m_tlast
);

    // a held result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // end marker always closes the request's results
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == bre_pkg::KIND_END |-> m_tlast && m_tdata == 16'd0)
        else $error("end marker malformed");

    // start colour is a single bit
    a_start_bit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == bre_pkg::KIND_START |-> m_tdata[15:1] == 15'd0)
        else $error("start colour wider than one bit");

    // runs are never empty
    a_run_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == bre_pkg::KIND_RUN |-> m_tdata != 16'd0)
        else $error("zero-length run");

endmodule

bind bilevel_rle_row_encoder bre_checker u_bre_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
